// ----- rtl/sgp_pkg.sv -----
// ----------------------------------------------------------------------------
// Spiral gradient pixel generator - shared definitions
// Field widths, register indexes, fixed-point angle constants, arctan table.
// ----------------------------------------------------------------------------
package sgp_pkg;

    localparam int XY_W  = 12;
    localparam int T_W   = 16;
    localparam int CFG_W = 12;
    localparam int IN_W  = 40;
    localparam int PIX_W = 32;
    localparam int PHW   = 19;

    localparam int DEF_COORD_BITS    = 12;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam logic       REG_FRAME_WIDTH  = 1'b0;
    localparam logic       REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd800;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd600;

    localparam logic [PHW-1:0] PI_Q16      = 19'd205887;
    localparam logic [PHW-1:0] HALF_PI_Q16 = 19'd102944;
    localparam logic [PHW-1:0] TWO_PI_Q16  = 19'd411775;

    localparam logic [10:0] COEF_003   = 11'd1966;
    localparam logic [11:0] COEF_005   = 12'd3277;
    localparam logic [31:0] CORDIC_K30 = 32'd652032875;
    localparam logic [7:0]  ALPHA      = 8'hFF;

    // arctan(2^-i) in Q.16 radians
    function automatic logic [16:0] atan_q16(input int unsigned i);
        logic [16:0] v;
        case (i)
            0:       v = 17'd51472;
            1:       v = 17'd30386;
            2:       v = 17'd16055;
            3:       v = 17'd8150;
            4:       v = 17'd4091;
            5:       v = 17'd2047;
            6:       v = 17'd1024;
            7:       v = 17'd512;
            8:       v = 17'd256;
            9:       v = 17'd128;
            10:      v = 17'd64;
            11:      v = 17'd32;
            12:      v = 17'd16;
            13:      v = 17'd8;
            14:      v = 17'd4;
            15:      v = 17'd2;
            16:      v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/spiral_gradient_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// Spiral gradient pixel generator
// Pixel coordinate and frame time in, packed RGBA colour out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while not held off and returns one colour word per
// pixel, in order. The pipeline holds the square root (one root bit per stage),
// the angle CORDIC and the sine CORDIC (one iteration per stage each), and the
// modulo-2pi reduction (one compare-subtract per stage). The input is held off
// only while the output register holds a result that has not been taken. The
// user must write frame width and height through the register port only while
// no pixel is in flight; the block itself does not enforce this.
module spiral_gradient_pixel_generator
    import sgp_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_W-1:0]   i_s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12], frame_time[39:24]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [PIX_W-1:0]  o_m_axis_tdata    // pixel_word[31:0]
);

    localparam int CM     = (COORD_BITS > 11) ? COORD_BITS : 11;
    localparam int CW     = CM + 1;
    localparam int SQW    = 2 * CM + 1;
    localparam int RW     = CM + 9;
    localparam int RADW   = COORD_BITS + 8;
    localparam int AW     = CM + 19;
    localparam int ZW     = 21;
    localparam int D3W    = RADW + 3;
    localparam int D5W    = RADW + 4;
    localparam int MW     = (D5W > 24) ? D5W : 24;
    localparam int KST    = MW - 18;
    localparam int SIDE_W = 2 * CW + T_W;
    localparam int NS     = CORDIC_STAGES;

    localparam logic [21:0] C2PI = 22'(TWO_PI_Q16);
    localparam logic [21:0] C4PI = C2PI << 1;
    localparam logic [21:0] C8PI = C2PI << 2;

    function automatic logic [21:0] f_red(input logic [21:0] v, input logic [21:0] c);
        return (v >= c) ? v - c : v;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
            endcase
        end
    end

    logic w_en;
    logic r_out_vld;
    logic [PIX_W-1:0] r_out_data;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // S1..S4: capture, centre, square, sum
    logic                    r1_vld, r2_vld, r3_vld, r4_vld;
    logic [COORD_BITS-1:0]   r1_px, r1_py;
    logic [T_W-1:0]          r1_t, r2_t, r3_t, r4_t;
    logic signed [CW-1:0]    r2_cx, r2_cy, r3_cx, r3_cy, r4_cx, r4_cy;
    logic [2*CM-1:0]         r3_sqx, r3_sqy;
    logic [SQW-1:0]          r4_sq;
    logic signed [2*CW-1:0]  w_sqx, w_sqy;

    assign w_sqx = r2_cx * r2_cx;
    assign w_sqy = r2_cy * r2_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_px  <= COORD_BITS'(i_s_axis_tdata[11:0]);
            r1_py  <= COORD_BITS'(i_s_axis_tdata[23:12]);
            r1_t   <= i_s_axis_tdata[39:24];
            r2_cx  <= $signed({1'b0, CM'(r1_px)}) - $signed({1'b0, CM'(r_frame_width[11:1])});
            r2_cy  <= $signed({1'b0, CM'(r1_py)}) - $signed({1'b0, CM'(r_frame_height[11:1])});
            r2_t   <= r1_t;
            r3_sqx <= w_sqx[2*CM-1:0];
            r3_sqy <= w_sqy[2*CM-1:0];
            r3_cx  <= r2_cx;
            r3_cy  <= r2_cy;
            r3_t   <= r2_t;
            r4_sq  <= {1'b0, r3_sqx} + {1'b0, r3_sqy};
            r4_cx  <= r3_cx;
            r4_cy  <= r3_cy;
            r4_t   <= r3_t;
        end
    end

    // radius
    logic              w_rt_vld;
    logic [RW-1:0]     w_root;
    logic [SIDE_W-1:0] w_side;

    sgp_isqrt #(
        .RW     (RW),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r4_vld),
        .i_n     ({1'b0, r4_sq, 16'h0000}),
        .i_side  ({r4_cx, r4_cy, r4_t}),
        .o_vld   (w_rt_vld),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    // S5: saturate radius, angle CORDIC set-up
    logic signed [CW-1:0] w_cx, w_cy;
    logic [T_W-1:0]       w_t;
    logic signed [AW-1:0] w_x0, w_y0;

    assign {w_cx, w_cy, w_t} = w_side;
    assign w_x0 = AW'($signed({w_cx, 16'h0000}));
    assign w_y0 = AW'($signed({w_cy, 16'h0000}));

    logic                  r5_vld, r5_zero;
    logic signed [AW-1:0]  r5_x, r5_y;
    logic signed [ZW-1:0]  r5_z;
    logic [RADW-1:0]       r5_rad;
    logic [T_W-1:0]        r5_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= w_rt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_rad  <= (|w_root[RW-1:RADW]) ? '1 : w_root[RADW-1:0];
            r5_t    <= w_t;
            r5_zero <= (w_cx == '0) && (w_cy == '0);
            if (w_cx[CW-1]) begin
                r5_x <= -w_x0;
                r5_y <= -w_y0;
                r5_z <= w_cy[CW-1] ? -$signed({2'b00, PI_Q16}) : $signed({2'b00, PI_Q16});
            end else begin
                r5_x <= w_x0;
                r5_y <= w_y0;
                r5_z <= '0;
            end
        end
    end

    // angle CORDIC, vectoring
    logic                  ra_vld  [NS];
    logic                  ra_zero [NS];
    logic signed [AW-1:0]  ra_x    [NS];
    logic signed [AW-1:0]  ra_y    [NS];
    logic signed [ZW-1:0]  ra_z    [NS];
    logic [RADW-1:0]       ra_rad  [NS];
    logic [T_W-1:0]        ra_t    [NS];

    for (genvar i = 0; i < NS; i++) begin : g_ang
        logic                 w_vld, w_zero;
        logic signed [AW-1:0] w_x, w_y;
        logic signed [ZW-1:0] w_z, w_at;
        logic [RADW-1:0]      w_rad;
        logic [T_W-1:0]       w_tt;

        assign w_at = $signed(ZW'(atan_q16(i)));

        if (i == 0) begin : g_first
            assign w_vld  = r5_vld;
            assign w_zero = r5_zero;
            assign w_x    = r5_x;
            assign w_y    = r5_y;
            assign w_z    = r5_z;
            assign w_rad  = r5_rad;
            assign w_tt   = r5_t;
        end else begin : g_next
            assign w_vld  = ra_vld[i-1];
            assign w_zero = ra_zero[i-1];
            assign w_x    = ra_x[i-1];
            assign w_y    = ra_y[i-1];
            assign w_z    = ra_z[i-1];
            assign w_rad  = ra_rad[i-1];
            assign w_tt   = ra_t[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                ra_vld[i] <= 1'b0;
            end else if (w_en) begin
                ra_vld[i] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                ra_zero[i] <= w_zero;
                ra_rad[i]  <= w_rad;
                ra_t[i]    <= w_tt;
                if (w_y[AW-1]) begin
                    ra_x[i] <= w_x - (w_y >>> i);
                    ra_y[i] <= w_y + (w_x >>> i);
                    ra_z[i] <= w_z - w_at;
                end else begin
                    ra_x[i] <= w_x + (w_y >>> i);
                    ra_y[i] <= w_y - (w_x >>> i);
                    ra_z[i] <= w_z + w_at;
                end
            end
        end
    end

    // S6: radius products
    logic [RADW+10:0]      w_p3;
    logic [RADW+11:0]      w_p5;
    logic                  r6_vld;
    logic [MW-1:0]         r6_d3, r6_d5, r6_t;
    logic signed [ZW-1:0]  r6_ang;

    assign w_p3 = (RADW+11)'(ra_rad[NS-1]) * (RADW+11)'(COEF_003);
    assign w_p5 = (RADW+12)'(ra_rad[NS-1]) * (RADW+12)'(COEF_005);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= ra_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_d3  <= MW'(w_p3[RADW+10:8]);
            r6_d5  <= MW'(w_p5[RADW+11:8]);
            r6_t   <= MW'({ra_t[NS-1], 8'h00});
            r6_ang <= ra_zero[NS-1] ? '0 : ra_z[NS-1];
        end
    end

    // modulo-2pi reduction, one binary multiple per stage
    logic                  rr_vld [KST];
    logic [MW-1:0]         rr_d3  [KST];
    logic [MW-1:0]         rr_d5  [KST];
    logic [MW-1:0]         rr_t   [KST];
    logic signed [ZW-1:0]  rr_ang [KST];

    for (genvar k = 0; k < KST; k++) begin : g_red
        localparam logic [MW-1:0] CK = MW'(TWO_PI_Q16) << (KST - 1 - k);
        logic                 w_vld;
        logic [MW-1:0]        w_d3, w_d5, w_tt;
        logic signed [ZW-1:0] w_ang;

        if (k == 0) begin : g_first
            assign w_vld = r6_vld;
            assign w_d3  = r6_d3;
            assign w_d5  = r6_d5;
            assign w_tt  = r6_t;
            assign w_ang = r6_ang;
        end else begin : g_next
            assign w_vld = rr_vld[k-1];
            assign w_d3  = rr_d3[k-1];
            assign w_d5  = rr_d5[k-1];
            assign w_tt  = rr_t[k-1];
            assign w_ang = rr_ang[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rr_vld[k] <= 1'b0;
            end else if (w_en) begin
                rr_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                rr_d3[k]  <= (w_d3 >= CK) ? w_d3 - CK : w_d3;
                rr_d5[k]  <= (w_d5 >= CK) ? w_d5 - CK : w_d5;
                rr_t[k]   <= (w_tt >= CK) ? w_tt - CK : w_tt;
                rr_ang[k] <= w_ang;
            end
        end
    end

    // P1..P5: phase sums and final wraps
    logic [21:0]          w_d3r, w_d5r, w_tr;
    logic signed [22:0]   w_sw;
    logic                 r7_vld, r8_vld, r9_vld, r10_vld, r11_vld;
    logic [21:0]          r7_w, r7_a, r7_b;
    logic [21:0]          r8_w, r8_a, r8_b;
    logic [21:0]          r9_w, r9_a, r9_b;
    logic [21:0]          r10_w, r10_a, r10_b;
    logic [PHW-1:0]       r11_w, r11_a, r11_b;

    assign w_d3r = 22'(rr_d3[KST-1][PHW-1:0]);
    assign w_d5r = 22'(rr_d5[KST-1][PHW-1:0]);
    assign w_tr  = 22'(rr_t[KST-1][PHW-1:0]);
    assign w_sw  = $signed({1'b0, w_d3r}) + $signed({1'b0, w_tr})
                 + 23'($signed({rr_ang[KST-1], 1'b0})) + $signed({1'b0, C4PI});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld  <= rr_vld[KST-1];
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_w  <= w_sw[21:0];
            r7_a  <= w_d5r + C4PI - {w_tr[20:0], 1'b0};
            r7_b  <= w_d3r + w_tr;
            r8_w  <= f_red(f_red(r7_w, C8PI), C4PI);
            r8_a  <= f_red(f_red(r7_a, C4PI), C2PI);
            r8_b  <= f_red(r7_b, C2PI);
            r9_w  <= f_red(r8_w, C2PI);
            r9_a  <= r8_a;
            r9_b  <= r8_b;
            r10_w <= r9_w + {r9_w[20:0], 1'b0};
            r10_a <= r9_a;
            r10_b <= r9_b;
            r11_w <= PHW'(f_red(f_red(r10_w, C4PI), C2PI));
            r11_a <= PHW'(r10_a);
            r11_b <= PHW'(r10_b);
        end
    end

    // sines
    logic             w_sn_vld;
    logic [2:0][15:0] w_m;

    sgp_sin3 #(
        .NS (NS)
    ) u_sin3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r11_vld),
        .i_ph    ({r11_b, r11_a, r11_w}),
        .o_vld   (w_sn_vld),
        .o_m     (w_m)
    );

    // colour mix
    logic         r12_vld;
    logic [31:0]  r12_p;
    logic [16:0]  r12_s;
    logic [15:0]  r12_c2;
    logic [39:0]  w_r255;
    logic [24:0]  w_g255;
    logic [23:0]  w_b255;

    assign w_r255 = {r12_p, 8'h00} - {8'h00, r12_p};
    assign w_g255 = 25'(r12_s) * 25'd255;
    assign w_b255 = 24'(r12_c2) * 24'd255;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r12_vld   <= w_sn_vld;
            r_out_vld <= r12_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_p      <= w_m[0] * w_m[1];
            r12_s      <= {1'b0, w_m[0]} + {1'b0, w_m[2]};
            r12_c2     <= w_m[2];
            r_out_data <= {w_r255[39:32], w_g255[24:17], w_b255[23:16], ALPHA};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> $stable(r_frame_width) && $stable(r_frame_height))
        else $error("frame size changed without a write");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result presented straight after reset");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !r12_vld |=> !o_m_axis_tvalid)
        else $error("result repeated after transfer");
`endif

endmodule

// ----- rtl/sgp_isqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage (restoring digit recurrence), sideband carried along.
// ----------------------------------------------------------------------------
module sgp_isqrt
    import sgp_pkg::*;
#(
    parameter int RW     = 21,
    parameter int SIDE_W = 50
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [2*RW-1:0]     i_n,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic [RW-1:0]       o_root,
    output logic [SIDE_W-1:0]   o_side
);

    logic              r_vld  [RW];
    logic [RW+1:0]     r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [2*RW-1:0]   r_n    [RW];
    logic [SIDE_W-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stg
        logic              w_vld;
        logic [RW+1:0]     w_rem;
        logic [RW-1:0]     w_root;
        logic [2*RW-1:0]   w_n;
        logic [SIDE_W-1:0] w_side;
        logic [RW+3:0]     w_pre;
        logic [RW+3:0]     w_trial;
        logic [RW+1:0]     n_rem;
        logic [RW-1:0]     n_root;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_n    = i_n;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_n    = r_n[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_pre   = {w_rem, w_n[2*RW-1 -: 2]};
        assign w_trial = {2'b00, w_root, 2'b01};

        always_comb begin
            if (w_pre >= w_trial) begin
                n_rem  = (RW+2)'(w_pre - w_trial);
                n_root = {w_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = w_pre[RW+1:0];
                n_root = {w_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_n[k]    <= {w_n[2*RW-3:0], 2'b00};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

// ----- rtl/sgp_sin3.sv -----
// ----------------------------------------------------------------------------
// Three-lane pipelined sine
// Quadrant fold, rotation CORDIC one iteration per stage, clamp and map to
// unsigned Q0.16.
// ----------------------------------------------------------------------------
module sgp_sin3
    import sgp_pkg::*;
#(
    parameter int NS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [2:0][PHW-1:0]  i_ph,
    output logic                 o_vld,
    output logic [2:0][15:0]     o_m
);

    localparam int SZ = 20;
    localparam int XW = 32;
    localparam logic signed [SZ-1:0] S_PI   = $signed({1'b0, PI_Q16});
    localparam logic signed [SZ-1:0] S_HPI  = $signed({1'b0, HALF_PI_Q16});
    localparam logic signed [SZ-1:0] S_2PI  = $signed({1'b0, TWO_PI_Q16});

    logic                  r_f_vld;
    logic signed [SZ-1:0]  r_f_z [3];
    logic signed [SZ-1:0]  w_fz  [3];

    logic                  r_c_vld [NS];
    logic signed [XW-1:0]  r_cx [NS][3];
    logic signed [XW-1:0]  r_cy [NS][3];
    logic signed [SZ-1:0]  r_cz [NS][3];

    logic                  r_o_vld;
    logic [2:0][15:0]      r_o_m;
    logic [2:0][15:0]      w_m;

    always_comb begin
        logic signed [SZ-1:0] p;
        for (int l = 0; l < 3; l++) begin
            p = $signed({1'b0, i_ph[l]});
            if (p > S_PI) begin
                p = p - S_2PI;
            end
            if (p > S_HPI) begin
                w_fz[l] = S_PI - p;
            end else if (p < -S_HPI) begin
                w_fz[l] = -S_PI - p;
            end else begin
                w_fz[l] = p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_z <= w_fz;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stg
        logic                 w_vld;
        logic signed [XW-1:0] w_x [3];
        logic signed [XW-1:0] w_y [3];
        logic signed [SZ-1:0] w_z [3];
        logic signed [XW-1:0] n_x [3];
        logic signed [XW-1:0] n_y [3];
        logic signed [SZ-1:0] n_z [3];
        logic signed [SZ-1:0] w_at;

        assign w_at = $signed(SZ'(atan_q16(i)));

        if (i == 0) begin : g_first
            assign w_vld = r_f_vld;
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign w_x[l] = $signed(CORDIC_K30);
                assign w_y[l] = '0;
                assign w_z[l] = r_f_z[l];
            end
        end else begin : g_next
            assign w_vld = r_c_vld[i-1];
            assign w_x   = r_cx[i-1];
            assign w_y   = r_cy[i-1];
            assign w_z   = r_cz[i-1];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                if (!w_z[l][SZ-1]) begin
                    n_x[l] = w_x[l] - (w_y[l] >>> i);
                    n_y[l] = w_y[l] + (w_x[l] >>> i);
                    n_z[l] = w_z[l] - w_at;
                end else begin
                    n_x[l] = w_x[l] + (w_y[l] >>> i);
                    n_y[l] = w_y[l] - (w_x[l] >>> i);
                    n_z[l] = w_z[l] + w_at;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_c_vld[i] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cx[i] <= n_x;
                r_cy[i] <= n_y;
                r_cz[i] <= n_z;
            end
        end
    end

    // floor to Q1.15, clamp, offset by one half
    always_comb begin
        logic signed [16:0] s;
        logic        [15:0] c;
        for (int l = 0; l < 3; l++) begin
            s = r_cy[NS-1][l][XW-1:15];
            if (s > 17'sd32767) begin
                c = 16'h7FFF;
            end else if (s < -17'sd32768) begin
                c = 16'h8000;
            end else begin
                c = s[15:0];
            end
            w_m[l] = {~c[15], c[14:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_c_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_m <= w_m;
        end
    end

    assign o_vld = r_o_vld;
    assign o_m   = r_o_m;

endmodule
